@@ hw/rtl/ssem_pkg.sv @@
// Shared types, codes and default sizes for the SSEM instruction core.
package ssem_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int WORD_BITS_DEF   = 32;
    localparam int STORE_WORDS_DEF = 32;

    // Instruction word layout.
    localparam int OPCODE_LSB      = 13;
    localparam int OPCODE_BITS     = 3;
    localparam int ADDR_FIELD_BITS = 5;

    // Request function codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_JMP     = 3'd0,
        OP_JRP     = 3'd1,
        OP_LDN     = 3'd2,
        OP_STO     = 3'd3,
        OP_SUB     = 3'd4,
        OP_SUB_ALT = 3'd5,
        OP_CMP     = 3'd6,
        OP_STP     = 3'd7
    } opcode_t;

    typedef struct packed {
        logic                       func;
        logic [ADDR_FIELD_BITS-1:0] load_address;
        logic [31:0]                load_word;
    } req_t;

    typedef struct packed {
        logic                   stepped;
        logic [OPCODE_BITS-1:0] opcode_done;
        logic [31:0]            control_counter;
        logic signed [31:0]     accumulator_value;
        logic                   halted;
    } rsp_t;

endpackage

@@ hw/rtl/ssem_instruction_core_unit.sv @@
// SSEM instruction core: store memory, CI, accumulator and stop flag with a step sequencer.
// Sequence: a request passes FETCH and EXEC, and its response registers in the output register;
//   a response held by rsp_ready keeps the next request in EXEC until the output register frees.
// Overlap: a new request can be taken as the current one retires (instruction read, then operand
//   read on one port); after a STO step the next request waits for the store write.
// Reset: CI, accumulator, stop flag and store valid bits clear at once, so no clearing pass.
module ssem_instruction_core_unit #(
    parameter int WORD_BITS   = ssem_pkg::WORD_BITS_DEF,
    parameter int STORE_WORDS = ssem_pkg::STORE_WORDS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ssem_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ssem_pkg::rsp_t rsp
);

    localparam int ADDR_BITS = $clog2(STORE_WORDS);

    // Sequencer: FETCH sees the instruction word, EXEC sees the operand word.
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } state_t;

    state_t                 state_reg, state_next;
    logic                   func_reg, func_next;
    ssem_pkg::opcode_t      op_reg, op_next;
    logic [ADDR_BITS-1:0]   s_reg, s_next;
    logic [WORD_BITS-1:0]   ci_reg, ci_next;
    logic [WORD_BITS-1:0]   acc_reg, acc_next;
    logic                   halted_reg, halted_next;
    logic [STORE_WORDS-1:0] valid_reg, valid_next;
    logic                   rvalid_reg, rvalid_next;
    logic                   out_valid_reg, out_valid_next;
    ssem_pkg::rsp_t         out_reg, out_next;

    // Store port signals.
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_BITS-1:0] ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] mem_word;

    // Address reduction.
    logic [WORD_BITS-1:0] ci_cur;
    logic [WORD_BITS-1:0] ci_fetch;
    logic [ADDR_BITS-1:0] fetch_addr;
    logic [ADDR_BITS-1:0] oper_addr;
    logic [ADDR_BITS-1:0] load_addr;

    // Execute results.
    logic                 active;
    logic [WORD_BITS-1:0] ci_inc;
    logic [WORD_BITS-1:0] ci_exec;
    logic [WORD_BITS-1:0] acc_exec;
    logic                 halt_exec;
    logic                 sto_exec;

    logic out_free;
    logic commit;
    logic accept;
    logic in_exec;

    ssem_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next fetch line: (CI after this request + 1) modulo the store depth.
    ssem_addr_mod #(
        .IN_BITS (WORD_BITS),
        .DIVISOR (STORE_WORDS)
    ) u_fetch_mod (
        .value   (ci_fetch),
        .residue (fetch_addr)
    );

    // Operand line from the instruction word arriving in FETCH.
    ssem_addr_mod #(
        .IN_BITS (ssem_pkg::ADDR_FIELD_BITS),
        .DIVISOR (STORE_WORDS)
    ) u_oper_mod (
        .value   (ssem_pkg::ADDR_FIELD_BITS'(mem_word)),
        .residue (oper_addr)
    );

    // Load line from the request.
    ssem_addr_mod #(
        .IN_BITS (ssem_pkg::ADDR_FIELD_BITS),
        .DIVISOR (STORE_WORDS)
    ) u_load_mod (
        .value   (req.load_address),
        .residue (load_addr)
    );

    // A word never written reads as zero, matching the cleared store.
    assign mem_word = rvalid_reg ? ram_rdata : '0;

    assign in_exec  = (state_reg == S_EXEC);
    assign out_free = !out_valid_reg || rsp_ready;
    assign commit   = in_exec && out_free;

    // Execute the held instruction against the operand word now on the read port.
    always_comb
    begin
        active    = (func_reg == ssem_pkg::FUNC_STEP) && !halted_reg;
        ci_inc    = ci_reg + WORD_BITS'(1);
        ci_exec   = ci_reg;
        acc_exec  = acc_reg;
        halt_exec = halted_reg;
        sto_exec  = 1'b0;
        if (active)
        begin
            ci_exec = ci_inc;
            case (op_reg)
                ssem_pkg::OP_JMP:
                begin
                    ci_exec = mem_word;
                end
                ssem_pkg::OP_JRP:
                begin
                    ci_exec = ci_inc + mem_word;
                end
                ssem_pkg::OP_LDN:
                begin
                    acc_exec = '0 - mem_word;
                end
                ssem_pkg::OP_STO:
                begin
                    sto_exec = 1'b1;
                end
                ssem_pkg::OP_SUB,
                ssem_pkg::OP_SUB_ALT:
                begin
                    acc_exec = acc_reg - mem_word;
                end
                ssem_pkg::OP_CMP:
                begin
                    // Skip the next instruction when A is negative.
                    if (acc_reg[WORD_BITS-1])
                    begin
                        ci_exec = ci_inc + WORD_BITS'(1);
                    end
                end
                default:
                begin
                    halt_exec = 1'b1;
                end
            endcase
        end
    end

    // Take a new request when idle, or in the cycle the current one retires.
    // Hold off during a STO retire: the write port is busy and the fetch would race it.
    assign req_ready = (state_reg == S_IDLE) || (commit && !sto_exec);
    assign accept    = req_valid && req_ready;

    // The fetch for a request taken in EXEC uses the CI that this cycle retires.
    assign ci_cur   = in_exec ? ci_exec : ci_reg;
    assign ci_fetch = ci_cur + WORD_BITS'(1);

    // Store ports: a load writes on acceptance, STO writes on retire; never both.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = load_addr;
        ram_wdata = WORD_BITS'(req.load_word);
        if (commit && sto_exec)
        begin
            ram_we    = 1'b1;
            ram_waddr = s_reg;
            ram_wdata = acc_reg;
        end
        else if (accept && (req.func == ssem_pkg::FUNC_LOAD))
        begin
            ram_we = 1'b1;
        end

        case (state_reg)
            S_FETCH:
            begin
                ram_raddr = oper_addr;
            end
            S_EXEC:
            begin
                // Fetch the next instruction on acceptance; else re-read the operand while the response slot is full.
                ram_raddr = accept ? fetch_addr : s_reg;
            end
            default:
            begin
                ram_raddr = fetch_addr;
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        func_next      = accept ? req.func : func_reg;
        op_next        = op_reg;
        s_next         = s_reg;
        ci_next        = ci_reg;
        acc_next       = acc_reg;
        halted_next    = halted_reg;
        valid_next     = valid_reg;
        rvalid_next    = valid_reg[ram_raddr];
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end

        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // Latch the decoded instruction; the operand read goes out now.
                op_next    = ssem_pkg::opcode_t'(ssem_pkg::OPCODE_BITS'(
                                 mem_word >> ssem_pkg::OPCODE_LSB));
                s_next     = oper_addr;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    ci_next     = ci_exec;
                    acc_next    = acc_exec;
                    halted_next = halt_exec;

                    out_valid_next             = 1'b1;
                    out_next.stepped           = active;
                    out_next.opcode_done       = active ? op_reg : ssem_pkg::OP_JMP;
                    out_next.control_counter   = 32'(ci_exec);
                    out_next.accumulator_value = 32'(acc_exec);
                    out_next.halted            = halt_exec;

                    state_next = accept ? S_FETCH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= ssem_pkg::FUNC_LOAD;
            op_reg        <= ssem_pkg::OP_JMP;
            s_reg         <= '0;
            ci_reg        <= '0;
            acc_reg       <= '0;
            halted_reg    <= 1'b0;
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            op_reg        <= op_next;
            s_reg         <= s_next;
            ci_reg        <= ci_next;
            acc_reg       <= acc_next;
            halted_reg    <= halted_next;
            valid_reg     <= valid_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

@@ hw/rtl/ssem_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module ssem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/ssem_addr_mod.sv @@
// Residue of a word modulo the store depth, by chunk tables and one fold.
module ssem_addr_mod #(
    parameter int IN_BITS = 32,
    parameter int DIVISOR = 32
) (
    input  logic [IN_BITS-1:0]         value,
    output logic [$clog2(DIVISOR)-1:0] residue
);

    localparam int RES_BITS   = $clog2(DIVISOR);
    localparam int CHUNK_BITS = 5;
    localparam int CHUNK_SIZE = 1 << CHUNK_BITS;
    localparam int CHUNKS     = (IN_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_BITS   = CHUNKS * CHUNK_BITS;
    localparam int SUM_BITS   = $clog2(CHUNKS * CHUNK_SIZE) + 1;
    localparam int HI_BITS    = SUM_BITS - CHUNK_BITS;
    localparam int HI_SIZE    = 1 << HI_BITS;

    // Residue of digit * 32^pos, worked out at elaboration.
    function automatic int chunk_residue(int pos, int digit);
        int w;
        w = 1 % DIVISOR;
        for (int k = 0; k < pos; k++)
        begin
            w = (w * CHUNK_SIZE) % DIVISOR;
        end
        return (digit * w) % DIVISOR;
    endfunction

    logic [PAD_BITS-1:0] padded;
    logic [RES_BITS-1:0] chunk_tab [CHUNKS][CHUNK_SIZE];
    logic [RES_BITS-1:0] hi_tab [HI_SIZE];
    logic [SUM_BITS-1:0] sum;
    logic [RES_BITS:0]   fold;

    assign padded = PAD_BITS'(value);

    for (genvar i = 0; i < CHUNKS; i++)
    begin : g_chunk
        for (genvar d = 0; d < CHUNK_SIZE; d++)
        begin : g_digit
            assign chunk_tab[i][d] = RES_BITS'(chunk_residue(i, d));
        end
    end

    for (genvar h = 0; h < HI_SIZE; h++)
    begin : g_hi
        assign hi_tab[h] = RES_BITS'(chunk_residue(1, h));
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < CHUNKS; i++)
        begin
            sum = sum + SUM_BITS'(chunk_tab[i][padded[i*CHUNK_BITS +: CHUNK_BITS]]);
        end
        // Fold the partial sum once more; the result stays below twice the divisor.
        fold = {1'b0, hi_tab[sum[SUM_BITS-1:CHUNK_BITS]]}
             + {1'b0, chunk_tab[0][sum[CHUNK_BITS-1:0]]};
        if (fold >= (RES_BITS+1)'(DIVISOR))
        begin
            residue = RES_BITS'(fold - (RES_BITS+1)'(DIVISOR));
        end
        else
        begin
            residue = RES_BITS'(fold);
        end
    end

endmodule
